### hdl/tfs_pkg.sv
// shared types and constants of the transmit frame scheduler
package tfs_pkg;

    localparam int QUEUE_DEPTH     = 4;
    localparam int SLOT_COUNT      = 2;
    localparam int CONTROL_MAX_LEN = 300;
    localparam int MODE_MAX_LEN    = 256;

    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int QLEN_W     = $clog2(CONTROL_MAX_LEN + 1);
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_LEN_W = 10;

    typedef enum logic [2:0] {
        REQ_ENQUEUE = 3'd0,
        REQ_PUBLISH = 3'd1,
        REQ_MODE_CHANGED = 3'd2,
        REQ_UPDATE = 3'd3,
        REQ_TX_DONE = 3'd4,
        REQ_TX_ERROR = 3'd5,
        REQ_SUSPEND = 3'd6
    } req_type_t;

    typedef enum logic [1:0] {
        SLOT_FREE = 2'd0,
        SLOT_PENDING = 2'd1,
        SLOT_SENDING = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_CONTROL = 2'd1,
        SRC_MODE = 2'd2
    } source_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BUSY = 2'd1;

    localparam logic START_FROM_FIFO = 1'b0;
    localparam logic START_FROM_SLOT = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] frame_length;
        logic [7:0]  mode_id;
        logic [31:0] generation;
        logic [15:0] seq_number;
        logic [1:0]  start_status;
        logic        suspend_flag;
    } req_item_t;

    typedef struct packed {
        logic        accepted;
        logic        start_issued;
        logic        start_source;
        logic [3:0]  start_index;
        logic [9:0]  start_length;
        logic [15:0] start_seq;
        logic [4:0]  queue_count;
        logic [1:0]  dropped_slots;
        logic        all_idle;
    } rsp_item_t;

endpackage

### hdl/tfs_if.sv
// request and result channel interfaces of the transmit frame scheduler
interface tfs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] frame_length;
    logic [7:0]  mode_id;
    logic [31:0] generation;
    logic [15:0] seq_number;
    logic [1:0]  start_status;
    logic        suspend_flag;

    modport source (
        output valid, req_type, frame_length, mode_id, generation, seq_number,
               start_status, suspend_flag,
        input  ready
    );
    modport sink (
        input  valid, req_type, frame_length, mode_id, generation, seq_number,
               start_status, suspend_flag,
        output ready
    );
endinterface

interface tfs_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        start_issued;
    logic        start_source;
    logic [3:0]  start_index;
    logic [9:0]  start_length;
    logic [15:0] start_seq;
    logic [4:0]  queue_count;
    logic [1:0]  dropped_slots;
    logic        all_idle;

    modport source (
        output valid, accepted, start_issued, start_source, start_index,
               start_length, start_seq, queue_count, dropped_slots, all_idle,
        input  ready
    );
    modport sink (
        input  valid, accepted, start_issued, start_source, start_index,
               start_length, start_seq, queue_count, dropped_slots, all_idle,
        output ready
    );
endinterface

### hdl/tfs_core.sv
// scheduler state: control fifo, mode slots, line tracking and per-beat update logic
module tfs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tfs_pkg::req_item_t item,
    output tfs_pkg::rsp_item_t result
);

    localparam int QD = tfs_pkg::QUEUE_DEPTH;
    localparam int SC = tfs_pkg::SLOT_COUNT;
    localparam int PW = tfs_pkg::QPTR_W;
    localparam int CW = tfs_pkg::QCNT_W;
    localparam int LW = tfs_pkg::QLEN_W;
    localparam int IW = tfs_pkg::SLOT_IDX_W;
    localparam int SW = tfs_pkg::SLOT_LEN_W;

    logic [LW-1:0] fifo_len_reg [QD];
    logic [LW-1:0] fifo_len_next [QD];
    logic [PW-1:0] rd_pos_reg, rd_pos_next;
    logic [PW-1:0] wr_pos_reg, wr_pos_next;
    logic [CW-1:0] count_reg, count_next;

    tfs_pkg::slot_state_t slot_state_reg [SC];
    tfs_pkg::slot_state_t slot_state_next [SC];
    logic [7:0]    slot_mode_reg [SC];
    logic [7:0]    slot_mode_next [SC];
    logic [31:0]   slot_gen_reg [SC];
    logic [31:0]   slot_gen_next [SC];
    logic [15:0]   slot_seq_reg [SC];
    logic [15:0]   slot_seq_next [SC];
    logic [SW-1:0] slot_len_reg [SC];
    logic [SW-1:0] slot_len_next [SC];

    tfs_pkg::source_t src_reg, src_next;
    logic [IW-1:0] act_slot_reg, act_slot_next;
    logic busy_reg, busy_next;
    logic done_pend_reg, done_pend_next;
    logic err_pend_reg, err_pend_next;
    logic suspended_reg, suspended_next;

    logic [IW-1:0] pick;
    logic          found;
    logic [1:0]    dropped;
    logic [LW-1:0] head_len;
    logic [SC-1:0] sending_vec;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(QD - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        fifo_len_next   = fifo_len_reg;
        rd_pos_next     = rd_pos_reg;
        wr_pos_next     = wr_pos_reg;
        count_next      = count_reg;
        slot_state_next = slot_state_reg;
        slot_mode_next  = slot_mode_reg;
        slot_gen_next   = slot_gen_reg;
        slot_seq_next   = slot_seq_reg;
        slot_len_next   = slot_len_reg;
        src_next        = src_reg;
        act_slot_next   = act_slot_reg;
        busy_next       = busy_reg;
        done_pend_next  = done_pend_reg;
        err_pend_next   = err_pend_reg;
        suspended_next  = suspended_reg;
        pick            = '0;
        found           = 1'b0;
        dropped         = '0;
        head_len        = '0;
        result          = '0;

        unique case (item.req_type)
            tfs_pkg::REQ_ENQUEUE:
            begin
                if (item.frame_length != '0
                    && item.frame_length <= 16'(tfs_pkg::CONTROL_MAX_LEN)
                    && count_reg < CW'(QD))
                begin
                    fifo_len_next[wr_pos_reg] = item.frame_length[LW-1:0];
                    wr_pos_next = ptr_inc(wr_pos_reg);
                    count_next = count_reg + CW'(1);
                    result.accepted = 1'b1;
                end
            end
            tfs_pkg::REQ_PUBLISH:
            begin
                if (!suspended_reg && item.frame_length != '0
                    && item.frame_length <= 16'(tfs_pkg::MODE_MAX_LEN))
                begin
                    // free slot first, else overwrite the first pending one
                    for (int i = 0; i < SC; i++)
                    begin
                        if (!found && slot_state_reg[i] == tfs_pkg::SLOT_FREE)
                        begin
                            pick = IW'(i);
                            found = 1'b1;
                        end
                    end
                    for (int i = 0; i < SC; i++)
                    begin
                        if (!found && slot_state_reg[i] == tfs_pkg::SLOT_PENDING)
                        begin
                            pick = IW'(i);
                            found = 1'b1;
                        end
                    end
                    if (found)
                    begin
                        slot_len_next[pick]   = item.frame_length[SW-1:0];
                        slot_mode_next[pick]  = item.mode_id;
                        slot_gen_next[pick]   = item.generation;
                        slot_seq_next[pick]   = item.seq_number;
                        slot_state_next[pick] = tfs_pkg::SLOT_PENDING;
                        result.accepted = 1'b1;
                    end
                end
            end
            tfs_pkg::REQ_MODE_CHANGED:
            begin
                for (int i = 0; i < SC; i++)
                begin
                    if (slot_state_reg[i] == tfs_pkg::SLOT_PENDING
                        && slot_mode_reg[i] == item.mode_id
                        && slot_gen_reg[i] == item.generation)
                    begin
                        slot_state_next[i] = tfs_pkg::SLOT_FREE;
                        dropped = dropped + 2'd1;
                    end
                end
            end
            tfs_pkg::REQ_UPDATE:
            begin
                if (err_pend_next)
                begin
                    err_pend_next = 1'b0;
                    if (src_next == tfs_pkg::SRC_MODE)
                    begin
                        slot_state_next[act_slot_next] = tfs_pkg::SLOT_FREE;
                        slot_mode_next[act_slot_next]  = '0;
                        slot_gen_next[act_slot_next]   = '0;
                        slot_seq_next[act_slot_next]   = '0;
                        slot_len_next[act_slot_next]   = '0;
                    end
                    src_next = tfs_pkg::SRC_NONE;
                    act_slot_next = '0;
                    busy_next = 1'b0;
                end
                if (done_pend_next)
                begin
                    done_pend_next = 1'b0;
                    if (src_next == tfs_pkg::SRC_CONTROL)
                    begin
                        if (count_next != '0)
                        begin
                            fifo_len_next[rd_pos_next] = '0;
                            rd_pos_next = ptr_inc(rd_pos_next);
                            count_next = count_next - CW'(1);
                        end
                    end
                    else if (src_next == tfs_pkg::SRC_MODE)
                    begin
                        slot_state_next[act_slot_next] = tfs_pkg::SLOT_FREE;
                        slot_mode_next[act_slot_next]  = '0;
                        slot_gen_next[act_slot_next]   = '0;
                        slot_seq_next[act_slot_next]   = '0;
                        slot_len_next[act_slot_next]   = '0;
                    end
                    src_next = tfs_pkg::SRC_NONE;
                    act_slot_next = '0;
                    busy_next = 1'b0;
                end
                if (!busy_next)
                begin
                    if (count_next != '0)
                    begin
                        head_len = fifo_len_next[rd_pos_next];
                        if (head_len != '0
                            && head_len <= LW'(tfs_pkg::CONTROL_MAX_LEN))
                        begin
                            if (item.start_status == tfs_pkg::STATUS_OK)
                            begin
                                src_next = tfs_pkg::SRC_CONTROL;
                                act_slot_next = '0;
                                busy_next = 1'b1;
                                result.start_issued = 1'b1;
                                result.start_source = tfs_pkg::START_FROM_FIFO;
                                result.start_index = 4'(rd_pos_next);
                                result.start_length = 10'(head_len);
                            end
                            else if (item.start_status != tfs_pkg::STATUS_BUSY)
                            begin
                                err_pend_next = 1'b1;
                            end
                        end
                    end
                    else if (!suspended_reg)
                    begin
                        // drop stale pending slots, keep the first matching one
                        for (int i = 0; i < SC; i++)
                        begin
                            if (slot_state_next[i] == tfs_pkg::SLOT_PENDING)
                            begin
                                if (slot_mode_next[i] != item.mode_id
                                    || slot_gen_next[i] != item.generation)
                                begin
                                    slot_state_next[i] = tfs_pkg::SLOT_FREE;
                                    slot_mode_next[i]  = '0;
                                    slot_gen_next[i]   = '0;
                                    slot_seq_next[i]   = '0;
                                    slot_len_next[i]   = '0;
                                    dropped = dropped + 2'd1;
                                end
                                else if (!found)
                                begin
                                    pick = IW'(i);
                                    found = 1'b1;
                                end
                            end
                        end
                        if (found)
                        begin
                            if (item.start_status == tfs_pkg::STATUS_OK)
                            begin
                                slot_state_next[pick] = tfs_pkg::SLOT_SENDING;
                                src_next = tfs_pkg::SRC_MODE;
                                act_slot_next = pick;
                                busy_next = 1'b1;
                                result.start_issued = 1'b1;
                                result.start_source = tfs_pkg::START_FROM_SLOT;
                                result.start_index = 4'(pick);
                                result.start_length = slot_len_next[pick];
                                result.start_seq = slot_seq_next[pick];
                            end
                            else if (item.start_status != tfs_pkg::STATUS_BUSY)
                            begin
                                slot_state_next[pick] = tfs_pkg::SLOT_FREE;
                                err_pend_next = 1'b1;
                            end
                        end
                    end
                end
            end
            tfs_pkg::REQ_TX_DONE:
            begin
                done_pend_next = 1'b1;
            end
            tfs_pkg::REQ_TX_ERROR:
            begin
                err_pend_next = 1'b1;
            end
            tfs_pkg::REQ_SUSPEND:
            begin
                suspended_next = item.suspend_flag;
                if (item.suspend_flag)
                begin
                    for (int i = 0; i < SC; i++)
                    begin
                        if (slot_state_reg[i] == tfs_pkg::SLOT_PENDING)
                        begin
                            slot_state_next[i] = tfs_pkg::SLOT_FREE;
                            slot_len_next[i] = '0;
                            dropped = dropped + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                // unknown request leaves state alone
            end
        endcase

        result.queue_count = 5'(count_next);
        result.dropped_slots = dropped;
        result.all_idle = !busy_next && count_next == '0;
        for (int i = 0; i < SC; i++)
        begin
            if (slot_state_next[i] != tfs_pkg::SLOT_FREE)
            begin
                result.all_idle = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QD; i++)
            begin
                fifo_len_reg[i] <= '0;
            end
            for (int i = 0; i < SC; i++)
            begin
                slot_state_reg[i] <= tfs_pkg::SLOT_FREE;
                slot_mode_reg[i]  <= '0;
                slot_gen_reg[i]   <= '0;
                slot_seq_reg[i]   <= '0;
                slot_len_reg[i]   <= '0;
            end
            rd_pos_reg    <= '0;
            wr_pos_reg    <= '0;
            count_reg     <= '0;
            src_reg       <= tfs_pkg::SRC_NONE;
            act_slot_reg  <= '0;
            busy_reg      <= 1'b0;
            done_pend_reg <= 1'b0;
            err_pend_reg  <= 1'b0;
            suspended_reg <= 1'b0;
        end
        else if (step)
        begin
            fifo_len_reg   <= fifo_len_next;
            slot_state_reg <= slot_state_next;
            slot_mode_reg  <= slot_mode_next;
            slot_gen_reg   <= slot_gen_next;
            slot_seq_reg   <= slot_seq_next;
            slot_len_reg   <= slot_len_next;
            rd_pos_reg     <= rd_pos_next;
            wr_pos_reg     <= wr_pos_next;
            count_reg      <= count_next;
            src_reg        <= src_next;
            act_slot_reg   <= act_slot_next;
            busy_reg       <= busy_next;
            done_pend_reg  <= done_pend_next;
            err_pend_reg   <= err_pend_next;
            suspended_reg  <= suspended_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < SC; i++)
        begin
            sending_vec[i] = (slot_state_reg[i] == tfs_pkg::SLOT_SENDING);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QD))
        else $error("control fifo count above depth");

    a_one_sending: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(sending_vec) <= 1)
        else $error("more than one mode slot sending");

    a_sending_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (|sending_vec) |-> (busy_reg && src_reg == tfs_pkg::SRC_MODE
                            && sending_vec[act_slot_reg]))
        else $error("sending slot not tracked as the active frame");

    a_busy_source: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (src_reg != tfs_pkg::SRC_NONE))
        else $error("line busy flag disagrees with active source");

endmodule

### hdl/tx_frame_scheduler.sv
// Transmit frame scheduler: takes one request beat per clock unless the result side stalls,
// and returns one result beat for each. A request sits in an input register, the scheduler
// state and the result are worked out from it combinationally, and the result lands in an
// output register; the block keeps a sustained rate of one request per cycle while results
// are taken. The state update is committed when a request leaves the input register,
// which only waits when the output register holds a result that has not been taken.
module tx_frame_scheduler (
    input  logic      clk,
    input  logic      rst_n,
    tfs_req_if.sink   req,
    tfs_rsp_if.source rsp
);

    logic               s1_valid_reg;
    tfs_pkg::req_item_t s1_item_reg;
    logic               rsp_valid_reg;
    tfs_pkg::rsp_item_t rsp_item_reg;
    tfs_pkg::rsp_item_t core_result;
    tfs_pkg::req_item_t in_item;
    logic               s1_move;

    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_move;

    always_comb
    begin
        in_item.req_type     = req.req_type;
        in_item.frame_length = req.frame_length;
        in_item.mode_id      = req.mode_id;
        in_item.generation   = req.generation;
        in_item.seq_number   = req.seq_number;
        in_item.start_status = req.start_status;
        in_item.suspend_flag = req.suspend_flag;
    end

    tfs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_move),
        .item   (s1_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_move)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_move)
        begin
            rsp_item_reg <= core_result;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.accepted      = rsp_item_reg.accepted;
    assign rsp.start_issued  = rsp_item_reg.start_issued;
    assign rsp.start_source  = rsp_item_reg.start_source;
    assign rsp.start_index   = rsp_item_reg.start_index;
    assign rsp.start_length  = rsp_item_reg.start_length;
    assign rsp.start_seq     = rsp_item_reg.start_seq;
    assign rsp.queue_count   = rsp_item_reg.queue_count;
    assign rsp.dropped_slots = rsp_item_reg.dropped_slots;
    assign rsp.all_idle      = rsp_item_reg.all_idle;

    a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !rsp_valid_reg) |=> rsp_valid_reg)
        else $error("pending beat did not reach the result register");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && rsp.ready) |=> !rsp_valid_reg)
        else $error("result beat appeared without a request");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && rsp_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("request taken while both stages are full");

endmodule

### tb/tfs_checker.sv
// checker for the transmit frame scheduler: predicts each result beat and compares it
module tfs_checker (
    input  logic clk,
    input  logic rst_n,
    tfs_req_if   req,
    tfs_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // predicted scheduler state
    logic [tfs_pkg::QLEN_W-1:0]     ctrl_len [tfs_pkg::QUEUE_DEPTH];
    logic [tfs_pkg::QPTR_W-1:0]     ctrl_rd;
    logic [tfs_pkg::QPTR_W-1:0]     ctrl_wr;
    logic [tfs_pkg::QCNT_W-1:0]     ctrl_cnt;
    tfs_pkg::slot_state_t           slot_st  [tfs_pkg::SLOT_COUNT];
    logic [7:0]                     slot_md  [tfs_pkg::SLOT_COUNT];
    logic [31:0]                    slot_gen [tfs_pkg::SLOT_COUNT];
    logic [15:0]                    slot_sq  [tfs_pkg::SLOT_COUNT];
    logic [tfs_pkg::SLOT_LEN_W-1:0] slot_len [tfs_pkg::SLOT_COUNT];
    tfs_pkg::source_t               act_src;
    logic [tfs_pkg::SLOT_IDX_W-1:0] act_slot;
    logic                           line_busy;
    logic                           done_pend;
    logic                           err_pend;
    logic                           suspended;

    tfs_pkg::rsp_item_t sched_results_due [$];

    function automatic logic [tfs_pkg::QPTR_W-1:0] next_pos(
        input logic [tfs_pkg::QPTR_W-1:0] pos);
        return (pos == tfs_pkg::QUEUE_DEPTH - 1) ? '0 : pos + 1'b1;
    endfunction

    task automatic wipe_slot(input int idx);
        slot_st[idx]  = tfs_pkg::SLOT_FREE;
        slot_md[idx]  = '0;
        slot_gen[idx] = '0;
        slot_sq[idx]  = '0;
        slot_len[idx] = '0;
    endtask

    task automatic advance_scheduler(input tfs_pkg::req_item_t r,
                                     output tfs_pkg::rsp_item_t e);
        int pick;
        int drops;
        int i;
        e = '0;
        drops = 0;
        unique case (r.req_type)
            tfs_pkg::REQ_ENQUEUE:
            begin
                if (r.frame_length != 0 && r.frame_length <= tfs_pkg::CONTROL_MAX_LEN
                    && ctrl_cnt < tfs_pkg::QUEUE_DEPTH)
                begin
                    ctrl_len[ctrl_wr] = r.frame_length[tfs_pkg::QLEN_W-1:0];
                    ctrl_wr = next_pos(ctrl_wr);
                    ctrl_cnt++;
                    e.accepted = 1'b1;
                end
            end
            tfs_pkg::REQ_PUBLISH:
            begin
                if (!suspended && r.frame_length != 0
                    && r.frame_length <= tfs_pkg::MODE_MAX_LEN)
                begin
                    pick = -1;
                    for (i = 0; i < tfs_pkg::SLOT_COUNT; i++)
                        if (pick < 0 && slot_st[i] == tfs_pkg::SLOT_FREE)
                            pick = i;
                    // no free slot: overwrite the first pending one
                    for (i = 0; i < tfs_pkg::SLOT_COUNT; i++)
                        if (pick < 0 && slot_st[i] == tfs_pkg::SLOT_PENDING)
                            pick = i;
                    if (pick >= 0)
                    begin
                        slot_len[pick] = r.frame_length[tfs_pkg::SLOT_LEN_W-1:0];
                        slot_md[pick]  = r.mode_id;
                        slot_gen[pick] = r.generation;
                        slot_sq[pick]  = r.seq_number;
                        slot_st[pick]  = tfs_pkg::SLOT_PENDING;
                        e.accepted = 1'b1;
                    end
                end
            end
            tfs_pkg::REQ_MODE_CHANGED:
            begin
                for (i = 0; i < tfs_pkg::SLOT_COUNT; i++)
                    if (slot_st[i] == tfs_pkg::SLOT_PENDING && slot_md[i] == r.mode_id
                        && slot_gen[i] == r.generation)
                    begin
                        slot_st[i] = tfs_pkg::SLOT_FREE;
                        drops++;
                    end
            end
            tfs_pkg::REQ_UPDATE:
            begin
                if (err_pend)
                begin
                    err_pend = 1'b0;
                    if (act_src == tfs_pkg::SRC_MODE)
                        wipe_slot(int'(act_slot));
                    act_src   = tfs_pkg::SRC_NONE;
                    act_slot  = '0;
                    line_busy = 1'b0;
                end
                if (done_pend)
                begin
                    done_pend = 1'b0;
                    if (act_src == tfs_pkg::SRC_CONTROL)
                    begin
                        if (ctrl_cnt > 0)
                        begin
                            ctrl_len[ctrl_rd] = '0;
                            ctrl_rd = next_pos(ctrl_rd);
                            ctrl_cnt--;
                        end
                    end
                    else if (act_src == tfs_pkg::SRC_MODE)
                    begin
                        wipe_slot(int'(act_slot));
                    end
                    act_src   = tfs_pkg::SRC_NONE;
                    act_slot  = '0;
                    line_busy = 1'b0;
                end
                if (!line_busy)
                begin
                    if (ctrl_cnt > 0)
                    begin
                        if (ctrl_len[ctrl_rd] != 0
                            && ctrl_len[ctrl_rd] <= tfs_pkg::CONTROL_MAX_LEN)
                        begin
                            if (r.start_status == tfs_pkg::STATUS_OK)
                            begin
                                act_src   = tfs_pkg::SRC_CONTROL;
                                act_slot  = '0;
                                line_busy = 1'b1;
                                e.start_issued = 1'b1;
                                e.start_source = tfs_pkg::START_FROM_FIFO;
                                e.start_index  = 4'(ctrl_rd);
                                e.start_length = 10'(ctrl_len[ctrl_rd]);
                            end
                            else if (r.start_status != tfs_pkg::STATUS_BUSY)
                            begin
                                err_pend = 1'b1;
                            end
                        end
                    end
                    else if (!suspended)
                    begin
                        pick = -1;
                        // stale pending slots are dropped on the way
                        for (i = 0; i < tfs_pkg::SLOT_COUNT; i++)
                            if (slot_st[i] == tfs_pkg::SLOT_PENDING)
                            begin
                                if (slot_md[i] != r.mode_id || slot_gen[i] != r.generation)
                                begin
                                    wipe_slot(i);
                                    drops++;
                                end
                                else if (pick < 0)
                                begin
                                    pick = i;
                                end
                            end
                        if (pick >= 0)
                        begin
                            if (r.start_status == tfs_pkg::STATUS_OK)
                            begin
                                slot_st[pick] = tfs_pkg::SLOT_SENDING;
                                act_src   = tfs_pkg::SRC_MODE;
                                act_slot  = tfs_pkg::SLOT_IDX_W'(pick);
                                line_busy = 1'b1;
                                e.start_issued = 1'b1;
                                e.start_source = tfs_pkg::START_FROM_SLOT;
                                e.start_index  = 4'(pick);
                                e.start_length = slot_len[pick];
                                e.start_seq    = slot_sq[pick];
                            end
                            else if (r.start_status != tfs_pkg::STATUS_BUSY)
                            begin
                                // slot fields stay, only the state goes back to free
                                slot_st[pick] = tfs_pkg::SLOT_FREE;
                                err_pend = 1'b1;
                            end
                        end
                    end
                end
            end
            tfs_pkg::REQ_TX_DONE:
                done_pend = 1'b1;
            tfs_pkg::REQ_TX_ERROR:
                err_pend = 1'b1;
            tfs_pkg::REQ_SUSPEND:
            begin
                suspended = r.suspend_flag;
                if (r.suspend_flag)
                    for (i = 0; i < tfs_pkg::SLOT_COUNT; i++)
                        if (slot_st[i] == tfs_pkg::SLOT_PENDING)
                        begin
                            slot_st[i]  = tfs_pkg::SLOT_FREE;
                            slot_len[i] = '0;
                            drops++;
                        end
            end
            default:
            begin
            end
        endcase
        e.queue_count   = 5'(ctrl_cnt);
        e.dropped_slots = 2'(drops);
        e.all_idle      = !line_busy && ctrl_cnt == 0;
        for (i = 0; i < tfs_pkg::SLOT_COUNT; i++)
            if (slot_st[i] != tfs_pkg::SLOT_FREE)
                e.all_idle = 1'b0;
    endtask

    function automatic string show_result(input tfs_pkg::rsp_item_t b);
        return $sformatf({"acc=%0d start=%0d src=%0d idx=%0d len=%0d seq=%0d",
                          " cnt=%0d drop=%0d idle=%0d"},
                         b.accepted, b.start_issued, b.start_source, b.start_index,
                         b.start_length, b.start_seq, b.queue_count, b.dropped_slots,
                         b.all_idle);
    endfunction

    task automatic note_failure(input string what, input tfs_pkg::rsp_item_t want,
                                input tfs_pkg::rsp_item_t got);
        if (fail_count < MAX_REPORTS)
            $display("%0t %s: expected {%s} got {%s}", $realtime, what,
                     show_result(want), show_result(got));
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tfs_pkg::req_item_t seen_req;
        tfs_pkg::rsp_item_t want;
        tfs_pkg::rsp_item_t got;
        int                 i;
        if (!rst_n)
        begin
            for (i = 0; i < tfs_pkg::QUEUE_DEPTH; i++)
                ctrl_len[i] = '0;
            for (i = 0; i < tfs_pkg::SLOT_COUNT; i++)
                wipe_slot(i);
            ctrl_rd    = '0;
            ctrl_wr    = '0;
            ctrl_cnt   = '0;
            act_src    = tfs_pkg::SRC_NONE;
            act_slot   = '0;
            line_busy  = 1'b0;
            done_pend  = 1'b0;
            err_pend   = 1'b0;
            suspended  = 1'b0;
            fail_count = 0;
            sched_results_due.delete();
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                seen_req = {req.req_type, req.frame_length, req.mode_id, req.generation,
                            req.seq_number, req.start_status, req.suspend_flag};
                advance_scheduler(seen_req, want);
                sched_results_due.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.accepted, rsp.start_issued, rsp.start_source, rsp.start_index,
                       rsp.start_length, rsp.start_seq, rsp.queue_count, rsp.dropped_slots,
                       rsp.all_idle};
                if (sched_results_due.size() == 0)
                begin
                    note_failure("result beat with nothing expected", '0, got);
                end
                else
                begin
                    want = sched_results_due.pop_front();
                    if (got.accepted !== want.accepted || got.start_issued !== want.start_issued
                        || got.start_source !== want.start_source
                        || got.start_index !== want.start_index
                        || got.start_length !== want.start_length
                        || got.start_seq !== want.start_seq
                        || got.queue_count !== want.queue_count
                        || got.dropped_slots !== want.dropped_slots
                        || got.all_idle !== want.all_idle)
                        note_failure("result mismatch", want, got);
                end
            end
        end
        outstanding = sched_results_due.size();
    end

endmodule

### tb/tb.sv
// top of the transmit frame scheduler testbench: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 6;
    localparam int MAX_GAP         = 16;
    localparam int RANDOM_ITEMS    = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;

    localparam logic [2:0] REQ_UNDEFINED    = 3'd7;
    localparam logic [1:0] STATUS_ERROR     = 2'd2;
    localparam logic [1:0] STATUS_ERROR_ALT = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   waiting_results;
    bit   tx_burst;
    logic [7:0]  live_mode;
    logic [31:0] live_gen;

    tfs_req_if req_ch ();
    tfs_rsp_if rsp_ch ();

    tx_frame_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tfs_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (mismatches),
        .outstanding (waiting_results)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic tfs_pkg::req_item_t make_req(input logic [2:0] kind,
                                                    input logic [15:0] len,
                                                    input logic [7:0] mode,
                                                    input logic [31:0] gen,
                                                    input logic [15:0] seq,
                                                    input logic [1:0] status,
                                                    input logic flag);
        tfs_pkg::req_item_t item;
        item.req_type     = kind;
        item.frame_length = len;
        item.mode_id      = mode;
        item.generation   = gen;
        item.seq_number   = seq;
        item.start_status = status;
        item.suspend_flag = flag;
        return item;
    endfunction

    // mostly a consistent mode/generation story, with stale frames and noise mixed in
    function automatic tfs_pkg::req_item_t random_request();
        tfs_pkg::req_item_t item;
        int                 pick;
        int                 roll;
        roll = $urandom_range(0, 99);
        item.req_type     = tfs_pkg::REQ_UPDATE;
        item.frame_length = 16'($urandom());
        item.mode_id      = live_mode;
        item.generation   = live_gen;
        item.seq_number   = 16'($urandom());
        item.start_status = (roll < 70) ? tfs_pkg::STATUS_OK :
                            (roll < 85) ? tfs_pkg::STATUS_BUSY :
                            (roll < 93) ? STATUS_ERROR : STATUS_ERROR_ALT;
        item.suspend_flag = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            item.req_type = tfs_pkg::REQ_ENQUEUE;
            if ($urandom_range(0, 9) != 0)
                item.frame_length = 16'($urandom_range(1, tfs_pkg::CONTROL_MAX_LEN));
        end
        else if (pick < 42)
        begin
            item.req_type = tfs_pkg::REQ_PUBLISH;
            if ($urandom_range(0, 9) != 0)
                item.frame_length = 16'($urandom_range(1, tfs_pkg::MODE_MAX_LEN));
            if ($urandom_range(0, 7) == 0)
            begin
                item.mode_id    = 8'($urandom());
                item.generation = $urandom();
            end
        end
        else if (pick < 66)
        begin
            item.req_type = tfs_pkg::REQ_UPDATE;
            if ($urandom_range(0, 9) == 0)
                item.mode_id = 8'($urandom());
        end
        else if (pick < 78)
        begin
            item.req_type = tfs_pkg::REQ_TX_DONE;
        end
        else if (pick < 84)
        begin
            item.req_type = tfs_pkg::REQ_TX_ERROR;
        end
        else if (pick < 90)
        begin
            // reports the old mode, then the stimulus may move on to a new one
            item.req_type = tfs_pkg::REQ_MODE_CHANGED;
            if ($urandom_range(0, 1) == 0)
            begin
                live_mode = 8'($urandom());
                live_gen  = ($urandom_range(0, 3) == 0) ? $urandom() : live_gen + 32'd1;
            end
        end
        else if (pick < 94)
        begin
            item.req_type = tfs_pkg::REQ_SUSPEND;
        end
        else
        begin
            item.req_type     = 3'($urandom_range(0, 7));
            item.mode_id      = 8'($urandom());
            item.generation   = $urandom();
            item.start_status = 2'($urandom());
        end
        return item;
    endfunction

    task automatic offer_request(input tfs_pkg::req_item_t item);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        {req_ch.req_type, req_ch.frame_length, req_ch.mode_id, req_ch.generation,
         req_ch.seq_number, req_ch.start_status, req_ch.suspend_flag} <= item;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (waiting_results != 0) @(negedge clk);
    endtask

    initial
    begin
        tfs_pkg::req_item_t script [$];
        tfs_pkg::req_item_t item;
        int                 sent;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        {req_ch.req_type, req_ch.frame_length, req_ch.mode_id, req_ch.generation,
         req_ch.seq_number, req_ch.start_status, req_ch.suspend_flag} = '0;
        tx_burst  = 1'b0;
        live_mode = 8'($urandom());
        live_gen  = $urandom();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        script = '{
            make_req(tfs_pkg::REQ_ENQUEUE, 16'd0, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_ENQUEUE, 16'(tfs_pkg::CONTROL_MAX_LEN + 1), 8'd0, 32'd0,
                     16'd0, tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_ENQUEUE, 16'(tfs_pkg::CONTROL_MAX_LEN), 8'd0, 32'd0,
                     16'd0, tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_ENQUEUE, 16'd1, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_ENQUEUE, 16'd2, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_ENQUEUE, 16'd3, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_ENQUEUE, 16'd4, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_PUBLISH, 16'd0, 8'hFF, 32'hFFFF_FFFF, 16'd7,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_PUBLISH, 16'(tfs_pkg::MODE_MAX_LEN + 1), 8'hFF,
                     32'hFFFF_FFFF, 16'd7, tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_PUBLISH, 16'(tfs_pkg::MODE_MAX_LEN), 8'hFF,
                     32'hFFFF_FFFF, 16'hFFFF, tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_PUBLISH, 16'd1, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_PUBLISH, 16'd16, 8'hFF, 32'hFFFF_FFFF, 16'h1234,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_UPDATE, 16'd0, 8'hFF, 32'hFFFF_FFFF, 16'd0,
                     tfs_pkg::STATUS_BUSY, 1'b0),
            make_req(tfs_pkg::REQ_TX_DONE, 16'd0, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_UPDATE, 16'd0, 8'hFF, 32'hFFFF_FFFF, 16'd0,
                     STATUS_ERROR, 1'b0),
            make_req(tfs_pkg::REQ_UPDATE, 16'd0, 8'hFF, 32'hFFFF_FFFF, 16'd0,
                     STATUS_ERROR_ALT, 1'b0),
            make_req(tfs_pkg::REQ_UPDATE, 16'd0, 8'hFF, 32'hFFFF_FFFF, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_TX_DONE, 16'd0, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_UPDATE, 16'd0, 8'hFF, 32'hFFFF_FFFF, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_TX_ERROR, 16'd0, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_UPDATE, 16'd0, 8'hFF, 32'hFFFF_FFFF, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_MODE_CHANGED, 16'd0, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_SUSPEND, 16'd0, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b1),
            make_req(tfs_pkg::REQ_PUBLISH, 16'd8, 8'd1, 32'd1, 16'd1,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(tfs_pkg::REQ_SUSPEND, 16'd0, 8'd0, 32'd0, 16'd0,
                     tfs_pkg::STATUS_OK, 1'b0),
            make_req(REQ_UNDEFINED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF,
                     STATUS_ERROR_ALT, 1'b1)
        };
        foreach (script[k])
            offer_request(script[k]);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 50 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            // halfway through the sender goes quiet until every result is back
            if (sent == RANDOM_ITEMS / 2)
            begin
                drain_results();
                sent++;
            end
            item = random_request();
            offer_request(item);
            if (item.req_type != REQ_UNDEFINED)
                sent++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[tx_frame_scheduler] OK");
        else
            $display("[tx_frame_scheduler] ERROR");
        $finish;
    end

    // result side: random stalls, bursts of steady readiness, and two long hold-offs
    initial
    begin
        int taken;
        int stall;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (taken == 400 || taken == 1500)
                stall = HOLD_OFF_CYCLES;
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            taken++;
        end
    end

    // ends the run when no beat moves on either channel for too long
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[tx_frame_scheduler] ERROR");
        $finish;
    end

endmodule

### tx_frame_scheduler.f
hdl/tfs_pkg.sv
hdl/tfs_if.sv
hdl/tfs_core.sv
hdl/tx_frame_scheduler.sv
tb/tfs_checker.sv
tb/tb.sv
